/* hw/rtl/per_client_token_bucket_policer_unit_defines.svh */
// Assertion macros shared by the policer RTL.
`ifndef PER_CLIENT_TOKEN_BUCKET_POLICER_UNIT_DEFINES_SVH
`define PER_CLIENT_TOKEN_BUCKET_POLICER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define CTBP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("ctbp assertion failed");
`define CTBP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	`CTBP_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define CTBP_ASSERT(lbl, clk, rst_n, prop)
`define CTBP_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* hw/rtl/ctbp_pkg.sv */
// Shared types and constants of the per-client token bucket policer.
`timescale 1ns / 1ps
package ctbp_pkg;
	localparam int TABLE_ENTRIES_DEF   = 16;
	localparam int TOKEN_FRAC_BITS_DEF = 16;

	localparam int CAP_W      = 16;
	localparam int PERIOD_W   = 27;
	localparam int TIMEOUT_W  = 32;
	localparam int KEY_W      = 32;
	localparam int TIME_W     = 48;
	localparam int VERDICT_W  = 2;
	localparam int CNT_OUT_W  = 5;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CAP_W-1:0]     CAP_RESET     = CAP_W'(100);
	localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = PERIOD_W'(1000);
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(5000);

	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_SWEEP   = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAPACITY = 2'd0,
		CFG_PERIOD   = 2'd1,
		CFG_TIMEOUT  = 2'd2
	} cfg_reg_t;

	typedef enum logic [VERDICT_W-1:0] {
		V_ALLOWED = 2'd0,
		V_LIMITED = 2'd1,
		V_FULL    = 2'd2,
		V_SWEEP   = 2'd3
	} verdict_t;

	typedef struct packed {
		logic accept;
		logic eval;
		logic step;
		logic decide;
		logic fetch;
		logic load_div;
		logic div_step;
		logic update;
		logic emit;
	} ctbp_cmd_t;

	typedef struct packed {
		logic is_sweep;
		logic last_idx;
		logic refused;
		logic div_last;
		logic out_free;
	} ctbp_status_t;
endpackage

/* hw/rtl/ctbp_if.sv */
// Request and result channel interfaces of the policer.
`timescale 1ns / 1ps
interface ctbp_in_if;
	import ctbp_pkg::*;
	logic                valid;
	logic                ready;
	logic                kind;
	logic [KEY_W-1:0]    client_key;
	logic [TIME_W-1:0]   now_ms;
	modport source(output valid, kind, client_key, now_ms, input ready);
	modport sink(input valid, kind, client_key, now_ms, output ready);
endinterface

interface ctbp_out_if;
	import ctbp_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [VERDICT_W-1:0] verdict;
	logic [CNT_OUT_W-1:0] removed_count;
	logic [CNT_OUT_W-1:0] active_count;
	modport source(output valid, verdict, removed_count, active_count, input ready);
	modport sink(input valid, verdict, removed_count, active_count, output ready);
endinterface

/* hw/rtl/ctbp_ctrl.sv */
// Sequencer of the policer: walks the table, runs the divider, emits results.
`timescale 1ns / 1ps
module ctbp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  ready,
	input  ctbp_pkg::ctbp_status_t sts,
	output ctbp_pkg::ctbp_cmd_t    cmd
);
	import ctbp_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_RD    = 9'b000000010,
		S_CMP   = 9'b000000100,
		S_LOOK  = 9'b000001000,
		S_FETCH = 9'b000010000,
		S_MUL   = 9'b000100000,
		S_DIV   = 9'b001000000,
		S_UPD   = 9'b010000000,
		S_EMIT  = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	assign ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_RD;
				end
			end
			S_RD: state_d = S_CMP;
			S_CMP: begin
				cmd.eval = 1'b1;
				if (sts.last_idx) begin
					state_d = sts.is_sweep ? S_EMIT : S_LOOK;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_RD;
				end
			end
			S_LOOK: begin
				cmd.decide = 1'b1;
				state_d    = sts.refused ? S_EMIT : S_FETCH;
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = S_MUL;
			end
			S_MUL: begin
				cmd.load_div = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = S_UPD;
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

/* hw/rtl/ctbp_dp.sv */
// Datapath of the policer: tables, refill divider, config and result registers.
`timescale 1ns / 1ps
`include "per_client_token_bucket_policer_unit_defines.svh"
module ctbp_dp #(
	parameter int TABLE_ENTRIES   = ctbp_pkg::TABLE_ENTRIES_DEF,
	parameter int TOKEN_FRAC_BITS = ctbp_pkg::TOKEN_FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ctbp_pkg::ctbp_cmd_t            cmd,
	output ctbp_pkg::ctbp_status_t         sts,
	input  logic                           in_kind,
	input  logic [ctbp_pkg::KEY_W-1:0]     in_key,
	input  logic [ctbp_pkg::TIME_W-1:0]    in_now,
	input  logic                           cfg_we,
	input  logic [ctbp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ctbp_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ctbp_pkg::VERDICT_W-1:0] out_verdict,
	output logic [ctbp_pkg::CNT_OUT_W-1:0] out_removed,
	output logic [ctbp_pkg::CNT_OUT_W-1:0] out_active
);
	import ctbp_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_ENTRIES);
	localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
	localparam int LVL_W  = CAP_W + TOKEN_FRAC_BITS;
	localparam int QW     = LVL_W + 1;
	localparam int PROD_W = CAP_W + PERIOD_W;
	localparam int NUM_W  = PROD_W + TOKEN_FRAC_BITS;
	localparam int DCNT_W = $clog2(NUM_W);

	logic [CAP_W-1:0]     cap_q;
	logic [PERIOD_W-1:0]  period_q;
	logic [TIMEOUT_W-1:0] timeout_q;

	logic              kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [TIME_W-1:0] now_q;

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         removed_q;
	logic [IDX_W-1:0]         idx_q, hit_idx_q, free_idx_q, slot_q;
	logic                     hit_q, free_q, new_q;
	verdict_t                 verdict_q;

	logic [KEY_W-1:0]  key_mem  [TABLE_ENTRIES];
	logic [LVL_W-1:0]  lvl_mem  [TABLE_ENTRIES];
	logic [TIME_W-1:0] last_mem [TABLE_ENTRIES];
	logic [KEY_W-1:0]  rd_key_q;
	logic [LVL_W-1:0]  rd_lvl_q;
	logic [TIME_W-1:0] rd_last_q;
	logic [IDX_W-1:0]  rd_addr;

	logic [LVL_W-1:0]  base_q;
	logic [NUM_W-1:0]  num_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [QW-1:0]     quo_q;
	logic [DCNT_W-1:0] dcnt_q;

	logic                 out_valid_q;
	logic [VERDICT_W-1:0] out_verdict_q;
	logic [CNT_OUT_W-1:0] out_removed_q, out_active_q;

	// elapsed / idle time against the entry just read
	logic [TIME_W-1:0]   since;
	logic                stale;
	logic [PERIOD_W-1:0] period_eff, elapsed;
	logic [PROD_W-1:0]   prod;
	logic [PERIOD_W:0]   trial;
	logic                ge;
	logic [QW-1:0]       sum;
	logic [LVL_W-1:0]    full, one, capped;
	logic                store_new;

	assign since      = (now_q >= rd_last_q) ? (now_q - rd_last_q) : '0;
	assign stale      = since > TIME_W'(timeout_q);
	assign period_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;
	assign elapsed    = new_q ? '0 :
	                    (since > TIME_W'(period_eff)) ? period_eff : since[PERIOD_W-1:0];
	assign prod       = PROD_W'(cap_q) * PROD_W'(elapsed);
	assign trial      = {rem_q, num_q[NUM_W-1]};
	assign ge         = trial >= {1'b0, period_eff};
	assign full       = {cap_q, {TOKEN_FRAC_BITS{1'b0}}};
	assign one        = LVL_W'(1) << TOKEN_FRAC_BITS;
	assign sum        = {1'b0, base_q} + quo_q;
	assign capped     = (sum > {1'b0, full}) ? full : sum[LVL_W-1:0];
	assign store_new  = cmd.decide && !hit_q && free_q;
	assign rd_addr    = cmd.fetch ? slot_q : idx_q;

	assign sts.is_sweep = (kind_q == KIND_SWEEP);
	assign sts.last_idx = (idx_q == IDX_W'(TABLE_ENTRIES - 1));
	assign sts.refused  = !hit_q && !free_q;
	assign sts.div_last = (dcnt_q == DCNT_W'(NUM_W - 1));
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= CAP_RESET;
			period_q  <= PERIOD_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CAPACITY: cap_q     <= cfg_wdata[CAP_W-1:0];
				CFG_PERIOD:   period_q  <= cfg_wdata[PERIOD_W-1:0];
				CFG_TIMEOUT:  timeout_q <= cfg_wdata[TIMEOUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			count_q   <= '0;
			removed_q <= '0;
			idx_q     <= '0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			new_q     <= 1'b0;
			kind_q    <= KIND_REQUEST;
			verdict_q <= V_ALLOWED;
		end else begin
			if (cmd.accept) begin
				kind_q    <= in_kind;
				idx_q     <= '0;
				hit_q     <= 1'b0;
				free_q    <= 1'b0;
				removed_q <= '0;
				verdict_q <= (in_kind == KIND_SWEEP) ? V_SWEEP : V_ALLOWED;
			end
			if (cmd.step) idx_q <= idx_q + IDX_W'(1);
			if (cmd.eval) begin
				if (kind_q == KIND_SWEEP) begin
					if (valid_q[idx_q] && stale) begin
						valid_q[idx_q] <= 1'b0;
						removed_q      <= removed_q + CNT_W'(1);
						count_q        <= count_q - CNT_W'(1);
					end
				end else if (valid_q[idx_q]) begin
					if (!hit_q && rd_key_q == key_q) hit_q <= 1'b1;
				end else if (!free_q) begin
					free_q <= 1'b1;
				end
			end
			if (cmd.decide) begin
				if (hit_q) begin
					new_q <= 1'b0;
				end else if (free_q) begin
					new_q           <= 1'b1;
					valid_q[free_idx_q] <= 1'b1;
					count_q         <= count_q + CNT_W'(1);
				end else begin
					verdict_q <= V_FULL;
				end
			end
			if (cmd.update) verdict_q <= (capped >= one) ? V_ALLOWED : V_LIMITED;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q <= in_key;
			now_q <= in_now;
		end
		if (cmd.eval && kind_q == KIND_REQUEST) begin
			if (valid_q[idx_q] && !hit_q && rd_key_q == key_q) hit_idx_q <= idx_q;
			if (!valid_q[idx_q] && !free_q) free_idx_q <= idx_q;
		end
		if (cmd.decide) slot_q <= hit_q ? hit_idx_q : free_idx_q;
		if (cmd.load_div) begin
			base_q <= new_q ? full : rd_lvl_q;
			num_q  <= {prod, {TOKEN_FRAC_BITS{1'b0}}};
			rem_q  <= '0;
			quo_q  <= '0;
			dcnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= ge ? PERIOD_W'(trial - {1'b0, period_eff}) : trial[PERIOD_W-1:0];
			num_q  <= num_q << 1;
			quo_q  <= {quo_q[QW-2:0], ge};
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
	end

	// table memories
	always_ff @(posedge clk) begin
		if (store_new) key_mem[free_idx_q] <= key_q;
		if (cmd.update) begin
			lvl_mem[slot_q]  <= (capped >= one) ? (capped - one) : capped;
			last_mem[slot_q] <= now_q;
		end
		rd_key_q  <= key_mem[rd_addr];
		rd_lvl_q  <= lvl_mem[rd_addr];
		rd_last_q <= last_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_verdict_q <= verdict_q;
			out_removed_q <= CNT_OUT_W'(removed_q);
			out_active_q  <= CNT_OUT_W'(count_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign out_verdict = out_verdict_q;
	assign out_removed = out_removed_q;
	assign out_active  = out_active_q;

	`CTBP_ASSERT(a_count_matches_marks, clk, arst_n, CNT_W'($countones(valid_q)) == count_q)
	`CTBP_ASSERT(a_div_rem_in_range, clk, arst_n, cmd.div_step |-> rem_q < period_eff)
	`CTBP_ASSERT_NEVER(a_emit_into_busy, clk, arst_n, cmd.emit && out_valid_q && !out_ready)
endmodule

/* hw/rtl/per_client_token_bucket_policer_unit.sv */
// Top level of the per-client token bucket policer.
`timescale 1ns / 1ps
// Per-client token bucket policer. Each request names a client by a 32-bit key and
// carries the time in ms; the result is allowed, rate limited or table full, plus the
// number of clients held. A sweep request removes every entry idle strictly longer
// than idle_timeout_ms and reports how many went. One request is worked at a time.
// A request walks the table (one registered memory read and one compare per entry),
// fetches state and forms the refill product, runs the one-bit-per-cycle refill
// divider, then writes back and hands over the result. A table full refusal skips
// the divider; a sweep ends after the walk. The result sits in an output register,
// so a new request is taken while the previous result still waits. No clearing pass
// after reset.
module per_client_token_bucket_policer_unit #(
	parameter int TABLE_ENTRIES   = ctbp_pkg::TABLE_ENTRIES_DEF,
	parameter int TOKEN_FRAC_BITS = ctbp_pkg::TOKEN_FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	ctbp_in_if.sink                         req,
	ctbp_out_if.source                      res,
	input  logic                            cfg_we,
	input  logic [ctbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ctbp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import ctbp_pkg::*;

	ctbp_cmd_t    cmd;
	ctbp_status_t sts;

	// sequencer: accept, walk, divide, emit
	ctbp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.ready     (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// tables, refill arithmetic, config and result register
	ctbp_dp #(
		.TABLE_ENTRIES   (TABLE_ENTRIES),
		.TOKEN_FRAC_BITS (TOKEN_FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_kind     (req.kind),
		.in_key      (req.client_key),
		.in_now      (req.now_ms),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.out_valid   (res.valid),
		.out_ready   (res.ready),
		.out_verdict (res.verdict),
		.out_removed (res.removed_count),
		.out_active  (res.active_count)
	);
endmodule
